// ===== rtl/rmmst_pkg.sv =====
// Shared types and constants for the range min/max segment tree unit.
package rmmst_pkg;

  localparam logic signed [31:0] EMPTY_MIN = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] EMPTY_MAX = 32'sh8000_0000;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam int unsigned USED_W = 11;
  localparam logic [USED_W-1:0] USED_RESET = 11'd1024;

  typedef struct packed {
    logic signed [31:0] mn;
    logic signed [31:0] mx;
  } pair_t;

  localparam pair_t EMPTY_PAIR = '{mn: EMPTY_MIN, mx: EMPTY_MAX};

  typedef struct packed {
    logic               action;
    logic [9:0]         index;
    logic signed [31:0] value;
    logic [9:0]         query_left;
    logic [9:0]         query_right;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] range_min;
    logic signed [31:0] range_max;
    logic [31:0]        range_spread;
    logic               range_empty;
  } out_item_t;

endpackage

// ===== rtl/rmmst_minmax.sv =====
// Shared compare unit: merges two (minimum, maximum) pairs.
module rmmst_minmax (
  input  rmmst_pkg::pair_t a,
  input  rmmst_pkg::pair_t b,
  output rmmst_pkg::pair_t y
);
  import rmmst_pkg::*;

  always_comb begin
    y.mn = (b.mn < a.mn) ? b.mn : a.mn;
    y.mx = (b.mx > a.mx) ? b.mx : a.mx;
  end

endmodule

// ===== rtl/rmmst_node_ram.sv =====
// Node memory of the tree: one write port, one registered read port.
module rmmst_node_ram #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  rmmst_pkg::pair_t wdata,
  input  logic [AW-1:0]    raddr,
  output rmmst_pkg::pair_t rdata
);
  import rmmst_pkg::*;

  pair_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/range_min_max_segment_tree_unit.sv =====
// Range min/max unit: a segment tree of (min, max) pairs walked by a small sequencer.
// Reset: a clearing pass loads every node with the empty pair; busy is high.
// Write: the leaf is written on accept, then each ancestor takes a sibling read (WRD) and an
//   update (WUPD); a write whose index is past the used size is ignored. One item is in flight at a time.
// Query: accepted in IDLE, then a QL and a QR step per tree level visited (up to log2(SIZE)+1), then
//   QOUT issues the result. An empty range answers directly from IDLE; no receiver stall.
module range_min_max_segment_tree_unit #(
  parameter int SIZE = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  rmmst_pkg::in_item_t       in_data,
  output logic                      out_valid,
  output rmmst_pkg::out_item_t      out_data,
  input  logic                      cfg_wr_en,
  input  logic [10:0]               cfg_wr_data
);
  import rmmst_pkg::*;

  localparam int DEPTH = 2 * SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = AW + 1;

  typedef enum logic [6:0] {
    ST_CLR  = 7'b0000001,
    ST_IDLE = 7'b0000010,
    ST_WRD  = 7'b0000100,
    ST_WUPD = 7'b0001000,
    ST_QL   = 7'b0010000,
    ST_QR   = 7'b0100000,
    ST_QOUT = 7'b1000000
  } state_t;

  state_t          state_r, state_nxt;
  logic [USED_W-1:0] cfg_used_r;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic [NW-1:0]   node_r, node_nxt;
  logic [NW-1:0]   l_r, l_nxt;
  logic [NW-1:0]   r_r, r_nxt;
  pair_t           pair_r, pair_nxt;
  logic            acc_en_r, acc_en_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  pair_t           ram_wdata;
  logic [NW-1:0]   rd_node;
  pair_t           ram_rdata;
  pair_t           mm_y;

  logic [USED_W-1:0] used_eff;
  logic [USED_W-1:0] hi_clip;
  logic              q_empty;
  logic [NW-1:0]     parent;

  rmmst_node_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_node[AW-1:0]),
    .rdata (ram_rdata)
  );

  rmmst_minmax u_mm (
    .a (pair_r),
    .b (ram_rdata),
    .y (mm_y)
  );

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    used_eff = (32'(cfg_used_r) > SIZE) ? USED_W'(SIZE) : cfg_used_r;
    hi_clip  = ({1'b0, in_data.query_right} > (used_eff - USED_W'(1)))
             ? (used_eff - USED_W'(1)) : {1'b0, in_data.query_right};
    q_empty  = (used_eff == '0) || ({1'b0, in_data.query_left} > hi_clip);
    parent   = node_r >> 1;
  end

  always_comb begin
    case (state_r)
      ST_WRD:  rd_node = node_r ^ NW'(1);
      ST_QL:   rd_node = l_r;
      ST_QR:   rd_node = r_r - NW'(1);
      default: rd_node = l_r;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    node_nxt      = node_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    pair_nxt      = pair_r;
    acc_en_nxt    = 1'b0;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = clr_r;
    ram_wdata     = EMPTY_PAIR;

    // A read issued by a query state in the previous cycle is merged now.
    if (acc_en_r) begin
      pair_nxt = mm_y;
    end

    case (state_r)
      ST_CLR: begin
        ram_we  = 1'b1;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (in_data.action == ACT_WRITE) begin
            if ({1'b0, in_data.index} < used_eff) begin
              node_nxt  = NW'(SIZE) + NW'(in_data.index);
              ram_we    = 1'b1;
              ram_waddr = node_nxt[AW-1:0];
              ram_wdata = '{mn: in_data.value, mx: in_data.value};
              pair_nxt  = ram_wdata;
              state_nxt = ST_WRD;
            end
          end else if (q_empty) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{range_min: EMPTY_MIN, range_max: EMPTY_MAX,
                              range_spread: 32'd0, range_empty: 1'b1};
          end else begin
            pair_nxt  = EMPTY_PAIR;
            l_nxt     = NW'(SIZE) + NW'(in_data.query_left);
            r_nxt     = NW'(SIZE) + NW'(hi_clip) + NW'(1);
            state_nxt = ST_QL;
          end
        end
      end
      ST_WRD: begin
        state_nxt = ST_WUPD;
      end
      ST_WUPD: begin
        ram_we    = 1'b1;
        ram_waddr = parent[AW-1:0];
        ram_wdata = mm_y;
        pair_nxt  = mm_y;
        node_nxt  = parent;
        state_nxt = (parent == NW'(1)) ? ST_IDLE : ST_WRD;
      end
      ST_QL: begin
        if (l_r < r_r) begin
          if (l_r[0]) begin
            acc_en_nxt = 1'b1;
            l_nxt      = l_r + NW'(1);
          end
          state_nxt = ST_QR;
        end else begin
          state_nxt = ST_QOUT;
        end
      end
      ST_QR: begin
        if (r_r[0]) begin
          acc_en_nxt = 1'b1;
          r_nxt      = (r_r - NW'(1)) >> 1;
        end else begin
          r_nxt = r_r >> 1;
        end
        l_nxt     = l_r >> 1;
        state_nxt = ST_QL;
      end
      ST_QOUT: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{range_min: pair_r.mn, range_max: pair_r.mx,
                          range_spread: 32'(pair_r.mx) - 32'(pair_r.mn),
                          range_empty: 1'b0};
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      acc_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_used_r  <= USED_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      acc_en_r    <= acc_en_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cfg_used_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    node_r     <= node_nxt;
    l_r        <= l_nxt;
    r_r        <= r_nxt;
    pair_r     <= pair_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== tb/sv/tb_range_min_max_segment_tree_unit.sv =====
// Self-checking testbench for the range min/max segment tree unit.
`timescale 1ns / 1ps

module tb_range_min_max_segment_tree_unit;
  import rmmst_pkg::*;

  localparam int SIZE = 1024;
  localparam int RESET_CYCLES = 5;
  localparam int SETTLE_CYCLES = 64;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int ITEMS_PER_SEGMENT = 117;
  localparam int SEGMENTS_PER_PHASE = 4;
  localparam logic signed [31:0] I32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] I32_MIN = 32'sh8000_0000;

  typedef enum logic {ROW_ITEM, ROW_CONFIG} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [USED_W-1:0] used;
    in_item_t          item;
    logic              typed;
    out_item_t         answer;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  in_item_t          in_data = '0;
  logic              out_valid;
  out_item_t         out_data;
  logic              cfg_wr_en = 1'b0;
  logic [USED_W-1:0] cfg_wr_data = '0;

  // Typed expectation that travels with a directed query.
  logic              typed_valid = 1'b0;
  out_item_t         typed_answer = '0;

  logic signed [31:0] tree_mn [2*SIZE];
  logic signed [31:0] tree_mx [2*SIZE];
  logic [USED_W-1:0]  used_shadow;
  out_item_t          pending_answers [$];
  out_item_t          oldest;
  out_item_t          predicted;
  int unsigned        errors = 0;
  int unsigned        quiet_cycles = 0;
  stim_row_t          directed [$];

  range_min_max_segment_tree_unit #(.SIZE(SIZE)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int unsigned used_now();
    return (used_shadow > SIZE) ? SIZE : int'(used_shadow);
  endfunction

  function automatic void tree_store(logic [9:0] idx, logic signed [31:0] val);
    int unsigned p;
    if (idx >= used_now()) return;
    p = SIZE + idx;
    tree_mn[p] = val;
    tree_mx[p] = val;
    p = p >> 1;
    while (p >= 1) begin
      tree_mn[p] = (tree_mn[2*p] < tree_mn[2*p+1]) ? tree_mn[2*p] : tree_mn[2*p+1];
      tree_mx[p] = (tree_mx[2*p] > tree_mx[2*p+1]) ? tree_mx[2*p] : tree_mx[2*p+1];
      p = p >> 1;
    end
  endfunction

  function automatic out_item_t range_lookup(logic [9:0] lo_in, logic [9:0] hi_in);
    out_item_t   res;
    int unsigned used;
    int unsigned lo;
    int unsigned hi;
    int unsigned l;
    int unsigned r;
    logic        empty;
    used = used_now();
    lo = lo_in;
    hi = hi_in;
    res.range_min = I32_MAX;
    res.range_max = I32_MIN;
    if (used == 0) begin
      empty = 1'b1;
    end else begin
      if (hi > used - 1) hi = used - 1;
      empty = (lo > hi);
    end
    if (!empty) begin
      l = lo + SIZE;
      r = hi + SIZE + 1;
      while (l < r) begin
        if (l[0]) begin
          if (tree_mn[l] < res.range_min) res.range_min = tree_mn[l];
          if (tree_mx[l] > res.range_max) res.range_max = tree_mx[l];
          l++;
        end
        if (r[0]) begin
          r--;
          if (tree_mn[r] < res.range_min) res.range_min = tree_mn[r];
          if (tree_mx[r] > res.range_max) res.range_max = tree_mx[r];
        end
        l = l >> 1;
        r = r >> 1;
      end
    end
    res.range_spread = empty ? 32'd0 : (32'(res.range_max) - 32'(res.range_min));
    res.range_empty = empty;
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // Scoreboard and predictor, both on the rising edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 2*SIZE; k++) begin
        tree_mn[k] = I32_MAX;
        tree_mx[k] = I32_MIN;
      end
      used_shadow = USED_RESET;
      pending_answers.delete();
    end else begin
      if (out_valid) begin
        if (pending_answers.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        end else begin
          oldest = pending_answers.pop_front();
          check_field("range_min", oldest.range_min, out_data.range_min);
          check_field("range_max", oldest.range_max, out_data.range_max);
          check_field("range_spread", oldest.range_spread, out_data.range_spread);
          check_field("range_empty", 32'(oldest.range_empty), 32'(out_data.range_empty));
        end
      end
      if (cfg_wr_en) used_shadow = cfg_wr_data;
      if (start && !busy) begin
        if (in_data.action == ACT_QUERY) begin
          predicted = range_lookup(in_data.query_left, in_data.query_right);
          pending_answers.push_back(typed_valid ? typed_answer : predicted);
        end else begin
          tree_store(in_data.index, in_data.value);
        end
      end
    end
  end

  // Ends the run when neither side transfers anything for too long.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_range_min_max_segment_tree_unit: done, errors");
      $finish;
    end
  end

  task automatic send_item(in_item_t item, logic typed, out_item_t answer);
    @(negedge clk);
    start <= 1'b1;
    in_data <= item;
    typed_valid <= typed;
    typed_answer <= answer;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain_answers();
    @(negedge clk);
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // A write leaves no result behind, so the unit gets extra time before the register moves.
  task automatic write_used_size(logic [USED_W-1:0] val);
    drain_answers();
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic stim_row_t write_row(logic [9:0] idx, logic signed [31:0] val);
    stim_row_t row;
    row.kind = ROW_ITEM;
    row.used = '0;
    row.item = '{action: ACT_WRITE, index: idx, value: val, query_left: 10'd0,
                 query_right: 10'd0};
    row.typed = 1'b0;
    row.answer = '0;
    return row;
  endfunction

  function automatic stim_row_t query_row(logic [9:0] lo, logic [9:0] hi, logic typed,
                                          out_item_t answer);
    stim_row_t row;
    row.kind = ROW_ITEM;
    row.used = '0;
    row.item = '{action: ACT_QUERY, index: 10'd0, value: 32'sd0, query_left: lo,
                 query_right: hi};
    row.typed = typed;
    row.answer = answer;
    return row;
  endfunction

  function automatic stim_row_t config_row(logic [USED_W-1:0] val);
    stim_row_t row;
    row.kind = ROW_CONFIG;
    row.used = val;
    row.item = '0;
    row.typed = 1'b0;
    row.answer = '0;
    return row;
  endfunction

  function automatic logic signed [31:0] random_value();
    case ($urandom_range(0, 9))
      0: return I32_MIN;
      1: return I32_MAX;
      2, 3, 4: return 32'($urandom_range(0, 200)) - 32'd100;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t random_item();
    in_item_t    item;
    int unsigned used;
    int unsigned lo;
    used = used_now();
    // Fields the chosen action ignores still carry random bits.
    item = '{action: ACT_WRITE, index: 10'($urandom), value: $urandom,
             query_left: 10'($urandom), query_right: 10'($urandom)};
    if ($urandom_range(0, 1) == 0) begin
      item.action = ACT_WRITE;
      if (used > 0 && $urandom_range(0, 99) < 85) item.index = 10'($urandom_range(0, used - 1));
      item.value = random_value();
    end else begin
      item.action = ACT_QUERY;
      case ($urandom_range(0, 9))
        0: begin
          item.query_left = 10'd0;
          item.query_right = 10'd1023;
        end
        1: begin
          lo = $urandom_range(1, 1023);
          item.query_left = 10'(lo);
          item.query_right = 10'($urandom_range(0, lo - 1));
        end
        2, 3: ;
        default: begin
          lo = (used > 0) ? $urandom_range(0, used - 1) : $urandom_range(0, 1023);
          item.query_left = 10'(lo);
          item.query_right = 10'((lo + $urandom_range(0, 64) > 1023) ? 1023
                                 : lo + $urandom_range(0, 64));
        end
      endcase
    end
    return item;
  endfunction

  function automatic logic [USED_W-1:0] random_used_size();
    case ($urandom_range(0, 9))
      0: return 11'd1024;
      1: return 11'd2047;
      2: return 11'd1;
      3: return 11'd2;
      4: return 11'd0;
      5, 6: return 11'($urandom_range(3, 64));
      7: return 11'($urandom_range(65, 1023));
      8: return 11'($urandom_range(1025, 2046));
      default: return 11'd16;
    endcase
  endfunction

  initial begin
    int unsigned idle_pct [3];
    idle_pct = '{34, 46, 0};

    // Unwritten leaves hold the empty pair, whose spread wraps to one.
    directed.push_back(query_row(10'd0, 10'd1023, 1'b1, '{I32_MAX, I32_MIN, 32'd1, 1'b0}));
    directed.push_back(write_row(10'd0, I32_MIN));
    directed.push_back(write_row(10'd1023, I32_MAX));
    directed.push_back(query_row(10'd0, 10'd1023, 1'b1,
                                 '{I32_MIN, I32_MAX, 32'hFFFF_FFFF, 1'b0}));
    directed.push_back(query_row(10'd1, 10'd1022, 1'b1, '{I32_MAX, I32_MIN, 32'd1, 1'b0}));
    directed.push_back(query_row(10'd5, 10'd3, 1'b1, '{I32_MAX, I32_MIN, 32'd0, 1'b1}));
    directed.push_back(write_row(10'd512, 32'sd0));
    directed.push_back(query_row(10'd512, 10'd512, 1'b1, '{32'sd0, 32'sd0, 32'd0, 1'b0}));
    directed.push_back(write_row(10'd3, -32'sd7));
    directed.push_back(write_row(10'd700, 32'sd12345));
    directed.push_back(query_row(10'd2, 10'd800, 1'b0, '0));
    directed.push_back(config_row(11'd2047));
    directed.push_back(query_row(10'd0, 10'd1023, 1'b0, '0));
    directed.push_back(config_row(11'd1));
    directed.push_back(write_row(10'd1, 32'sd99));
    directed.push_back(query_row(10'd0, 10'd1023, 1'b1, '{I32_MIN, I32_MIN, 32'd0, 1'b0}));
    directed.push_back(query_row(10'd1, 10'd1023, 1'b1, '{I32_MAX, I32_MIN, 32'd0, 1'b1}));
    directed.push_back(config_row(11'd0));
    directed.push_back(write_row(10'd0, 32'sd5));
    directed.push_back(query_row(10'd0, 10'd0, 1'b1, '{I32_MAX, I32_MIN, 32'd0, 1'b1}));
    directed.push_back(config_row(11'd600));
    directed.push_back(write_row(10'd600, 32'sd1));
    directed.push_back(write_row(10'd599, -32'sd1));
    directed.push_back(query_row(10'd590, 10'd1023, 1'b0, '0));
    directed.push_back(query_row(10'd1023, 10'd1023, 1'b1, '{I32_MAX, I32_MIN, 32'd0, 1'b1}));

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CONFIG) write_used_size(directed[i].used);
      else send_item(directed[i].item, directed[i].typed, directed[i].answer);
    end
    write_used_size(11'd1024);

    for (int ph = 0; ph < 3; ph++) begin
      for (int seg = 0; seg < SEGMENTS_PER_PHASE; seg++) begin
        if (ph + seg > 0) write_used_size(random_used_size());
        for (int n = 0; n < ITEMS_PER_SEGMENT; n++) begin
          // Each cycle before the next item is left idle with the phase's probability.
          while ($urandom_range(0, 99) < idle_pct[ph]) begin
            @(negedge clk);
            start <= 1'b0;
          end
          if ($urandom_range(0, 99) < 2) drain_answers();
          send_item(random_item(), 1'b0, '0);
        end
      end
    end

    drain_answers();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("tb_range_min_max_segment_tree_unit: done, clean");
    end else begin
      $display("tb_range_min_max_segment_tree_unit: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rmmst_pkg.sv
rtl/rmmst_minmax.sv
rtl/rmmst_node_ram.sv
rtl/range_min_max_segment_tree_unit.sv
tb/sv/tb_range_min_max_segment_tree_unit.sv
